FILE: hdl/olss_pkg.sv
package olss_pkg;

   // Field widths of the transactions
   localparam int ACTION_W   = 3;
   localparam int POSITION_W = 4;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 5;

   // Default store depth
   localparam int OLSS_DEPTH = 16;

   // Action codes
   typedef enum logic [ACTION_W-1:0] {
      ACT_PREPEND    = 3'd0,
      ACT_APPEND     = 3'd1,
      ACT_INSERT     = 3'd2,
      ACT_POP        = 3'd3,
      ACT_REMOVE_AT  = 3'd4,
      ACT_REMOVE_VAL = 3'd5,
      ACT_READ_AT    = 3'd6
   } action_type;

   // Status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_FULL      = 3'd1,
      STAT_EMPTY     = 3'd2,
      STAT_BAD_INDEX = 3'd3,
      STAT_NOT_FOUND = 3'd4
   } status_type;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_READ,
      S_UP_WRITE,
      S_DN_READ,
      S_DN_WRITE,
      S_SCAN_READ,
      S_SCAN_CHECK,
      S_READ_ISSUE,
      S_READ_DONE
   } state_type;

   // Request transaction
   typedef struct packed {
      logic [ACTION_W-1:0]          action;
      logic [POSITION_W-1:0]        position;
      logic signed [VALUE_W-1:0]    value;
   } req_type;

   // Response transaction
   typedef struct packed {
      logic [STATUS_W-1:0]          status;
      logic [COUNT_W-1:0]           count;
      logic signed [VALUE_W-1:0]    read_data;
      logic [POSITION_W-1:0]        match_position;
   } rsp_type;

endpackage

FILE: hdl/ordered_list_shift_store.sv
// Channel    | Ports                    | Handshake
// -----------+--------------------------+------------------------------------------
// request    | start, busy, req_item    | taken on a clock edge with start=1, busy=0
// response   | rsp_strobe, rsp_item     | one cycle wide pulse, cannot be held off
//
// One memory port pair (one read, one write a cycle, registered read) holds the list.
// Refused actions, pop and the unused code: response in the cycle after the request.
// Prepend, append, insert: entries move up from the tail to the position (count for
// append), each a read then a write. Remove at moves later entries down; remove value
// first scans for an equal entry. Read at: one registered read. busy stays high until
// the response is issued. Synchronous reset empties the list; memory is not cleared.
module ordered_list_shift_store
   import olss_pkg::*;
#(
   parameter int DEPTH = OLSS_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // Packs a response, sizing count and match position to the field widths
   function automatic rsp_type pack_rsp(input status_type st, input logic [CW-1:0] cnt,
                                        input logic [VALUE_W-1:0] rd,
                                        input logic [CW-1:0] mp);
      logic [31:0] cnt_w;
      logic [31:0] mp_w;
      rsp_type     r;
      cnt_w            = 32'(cnt);
      mp_w             = 32'(mp);
      r.status         = st;
      r.count          = cnt_w[COUNT_W-1:0];
      r.read_data      = rd;
      r.match_position = mp_w[POSITION_W-1:0];
      return r;
   endfunction

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [CW-1:0]        mpos_ff, mpos_in;
   logic [VALUE_W-1:0]   val_ff, val_in;
   logic                 strobe_ff, strobe_in;
   rsp_type              rsp_ff, rsp_in;

   logic [VALUE_W-1:0]   mem [DEPTH];
   logic [VALUE_W-1:0]   rd_data_ff;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        wr_addr;
   logic [VALUE_W-1:0]   wr_data;
   logic                 wr_en;

   logic [CW-1:0]        idx_inc;
   logic [CW-1:0]        idx_dec;
   logic [CW-1:0]        req_pos;
   logic                 full;
   logic                 pos_ok;

   assign idx_inc = idx_ff + CW'(1);
   assign idx_dec = idx_ff - CW'(1);
   assign req_pos = CW'(req_item.position);
   assign full    = (count_ff == CW'(DEPTH));
   assign pos_ok  = (32'(req_item.position) < 32'(count_ff));

   // List store: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   // Working and response registers
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      pos_ff  <= pos_in;
      mpos_ff <= mpos_in;
      val_ff  <= val_in;
      rsp_ff  <= rsp_in;
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      mpos_in   = mpos_ff;
      val_in    = val_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff[AW-1:0];
      wr_data   = val_ff;
      rd_addr   = idx_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               val_in  = req_item.value;
               mpos_in = '0;
               idx_in  = '0;
               unique case (req_item.action)
                  ACT_PREPEND: begin
                     if (full) begin
                        strobe_in = 1'b1;
                        rsp_in    = pack_rsp(STAT_FULL, count_ff, '0, '0);
                     end else begin
                        idx_in   = count_ff;
                        pos_in   = '0;
                        state_in = S_UP_READ;
                     end
                  end
                  ACT_APPEND: begin
                     if (full) begin
                        strobe_in = 1'b1;
                        rsp_in    = pack_rsp(STAT_FULL, count_ff, '0, '0);
                     end else begin
                        idx_in   = count_ff;
                        pos_in   = count_ff;
                        state_in = S_UP_READ;
                     end
                  end
                  ACT_INSERT: begin
                     if (!pos_ok) begin
                        strobe_in = 1'b1;
                        rsp_in    = pack_rsp(STAT_BAD_INDEX, count_ff, '0, '0);
                     end else if (full) begin
                        strobe_in = 1'b1;
                        rsp_in    = pack_rsp(STAT_FULL, count_ff, '0, '0);
                     end else begin
                        idx_in   = count_ff;
                        pos_in   = req_pos;
                        state_in = S_UP_READ;
                     end
                  end
                  ACT_POP: begin
                     strobe_in = 1'b1;
                     if (count_ff == '0) begin
                        rsp_in = pack_rsp(STAT_EMPTY, count_ff, '0, '0);
                     end else begin
                        count_in = count_ff - CW'(1);
                        rsp_in   = pack_rsp(STAT_OK, count_in, '0, '0);
                     end
                  end
                  ACT_REMOVE_AT: begin
                     if (!pos_ok) begin
                        strobe_in = 1'b1;
                        rsp_in    = pack_rsp(STAT_BAD_INDEX, count_ff, '0, '0);
                     end else begin
                        idx_in   = req_pos;
                        state_in = S_DN_READ;
                     end
                  end
                  ACT_REMOVE_VAL: begin
                     state_in = S_SCAN_READ;
                  end
                  ACT_READ_AT: begin
                     if (!pos_ok) begin
                        strobe_in = 1'b1;
                        rsp_in    = pack_rsp(STAT_BAD_INDEX, count_ff, '0, '0);
                     end else begin
                        pos_in   = req_pos;
                        state_in = S_READ_ISSUE;
                     end
                  end
                  default: begin
                     // unused action code: no change
                     strobe_in = 1'b1;
                     rsp_in    = pack_rsp(STAT_OK, count_ff, '0, '0);
                  end
               endcase
            end
         end

         // Open a hole: move entries up from the tail until the target index
         S_UP_READ: begin
            if (idx_ff == pos_ff) begin
               wr_en     = 1'b1;
               wr_data   = val_ff;
               count_in  = count_ff + CW'(1);
               strobe_in = 1'b1;
               rsp_in    = pack_rsp(STAT_OK, count_in, '0, '0);
               state_in  = S_IDLE;
            end else begin
               rd_addr  = idx_dec[AW-1:0];
               state_in = S_UP_WRITE;
            end
         end
         S_UP_WRITE: begin
            wr_en    = 1'b1;
            wr_data  = rd_data_ff;
            idx_in   = idx_dec;
            state_in = S_UP_READ;
         end

         // Close a hole: move entries down towards the removed index
         S_DN_READ: begin
            if (idx_inc == count_ff) begin
               count_in  = count_ff - CW'(1);
               strobe_in = 1'b1;
               rsp_in    = pack_rsp(STAT_OK, count_in, '0, mpos_ff);
               state_in  = S_IDLE;
            end else begin
               rd_addr  = idx_inc[AW-1:0];
               state_in = S_DN_WRITE;
            end
         end
         S_DN_WRITE: begin
            wr_en    = 1'b1;
            wr_data  = rd_data_ff;
            idx_in   = idx_inc;
            state_in = S_DN_READ;
         end

         // Linear search for the first equal entry
         S_SCAN_READ: begin
            if (idx_ff == count_ff) begin
               strobe_in = 1'b1;
               rsp_in    = pack_rsp(STAT_NOT_FOUND, count_ff, '0, '0);
               state_in  = S_IDLE;
            end else begin
               state_in = S_SCAN_CHECK;
            end
         end
         S_SCAN_CHECK: begin
            if (rd_data_ff == val_ff) begin
               mpos_in  = idx_ff;
               state_in = S_DN_READ;
            end else begin
               idx_in   = idx_inc;
               state_in = S_SCAN_READ;
            end
         end

         // Single entry read
         S_READ_ISSUE: begin
            rd_addr  = pos_ff[AW-1:0];
            state_in = S_READ_DONE;
         end
         S_READ_DONE: begin
            strobe_in = 1'b1;
            rsp_in    = pack_rsp(STAT_OK, count_ff, rd_data_ff, '0);
            state_in  = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

FILE: hdl/olss_checker.sv
module olss_checker
   import olss_pkg::*;
#(
   parameter int DEPTH = OLSS_DEPTH
) (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   // A response only follows an accepted request or work in progress
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(start) || $past(busy)))
      else $error("response without a request");

   // Refused actions return no read data and no match position
   a_refused_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.status != STAT_OK))
         |-> ((rsp_item.read_data == '0) && (rsp_item.match_position == '0)))
      else $error("refused action returned data");

   // Full is only reported with the store at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.status == STAT_FULL))
         |-> (rsp_item.count == COUNT_W'(DEPTH)))
      else $error("full reported below capacity");

   // Empty is only reported with no entries
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.status == STAT_EMPTY)) |-> (rsp_item.count == '0))
      else $error("empty reported with entries held");

endmodule

bind ordered_list_shift_store olss_checker #(.DEPTH(DEPTH)) u_olss_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);
